// File: design/pbpd_pkg.sv
// ----------------------------------------------------------------------------
// pbpd_pkg: shared definitions for the burst preamble deframer
// Header window type, preamble sync words and the front verdict function.
// ----------------------------------------------------------------------------
package pbpd_pkg;

	localparam int WIN_DEPTH = 12;
	localparam int FILL_W    = 4;
	localparam int LEFT_W    = 21;

	typedef logic [WIN_DEPTH-1:0][7:0] win_t;

	// Index 0 is the first byte on the stream.
	localparam logic [5:0][7:0] SYNC24 = {8'h1f, 8'h4e, 8'ha5, 8'h72, 8'hf8, 8'h96};
	localparam logic [3:0][7:0] SYNC16 = {8'h1f, 8'h4e, 8'h72, 8'hF8};

	// Verdict on the byte at the front of the window.
	localparam logic [1:0] VERD_WAIT  = 2'd0;
	localparam logic [1:0] VERD_DROP  = 2'd1;
	localparam logic [1:0] VERD_ACC24 = 2'd2;
	localparam logic [1:0] VERD_ACC16 = 2'd3;

	// Judges a window whose first m bytes are valid against both preamble forms.
	function automatic logic [1:0] judge_front(input win_t w, input logic [FILL_W-1:0] m,
		input logic [4:0] want);
		logic       bad;
		logic [1:0] v;
		bad = 1'b0;
		v   = VERD_DROP;
		if (m == '0) begin
			v = VERD_WAIT;
		end else if (w[0] == SYNC24[0]) begin
			for (int i = 0; i < 6; i++) begin
				if (FILL_W'(i) < m && w[i] != SYNC24[i]) bad = 1'b1;
			end
			if (bad) v = VERD_DROP;
			else if (m < FILL_W'(9)) v = VERD_WAIT;
			else if (w[8][4:0] != want) v = VERD_DROP;
			else if (m < FILL_W'(12)) v = VERD_WAIT;
			else v = VERD_ACC24;
		end else if (w[0] == SYNC16[0]) begin
			for (int i = 0; i < 4; i++) begin
				if (FILL_W'(i) < m && w[i] != SYNC16[i]) bad = 1'b1;
			end
			if (bad) v = VERD_DROP;
			else if (m < FILL_W'(6)) v = VERD_WAIT;
			else if (w[5][4:0] != want) v = VERD_DROP;
			else if (m < FILL_W'(8)) v = VERD_WAIT;
			else v = VERD_ACC16;
		end
		return v;
	endfunction

endpackage

// File: design/pcm_burst_preamble_deframer.sv
// ----------------------------------------------------------------------------
// pcm_burst_preamble_deframer: burst preamble hunter and payload extractor
// Finds 16-bit and 24-bit burst preambles of the configured data type in a
// byte stream and passes out the burst payload bytes with the header fields.
// ----------------------------------------------------------------------------
// The block takes one stream byte per beat and can take a new beat in every
// cycle; each input beat gives at most one output beat, registered, in the
// cycle after it is accepted. While hunting, bytes collect in a 12-byte header
// window. Every cycle the window is judged at all start offsets in parallel
// and the first offset that may still begin a preamble becomes the new front,
// so any number of dead bytes are discarded in that same cycle. A 24-bit
// header (96 F8 72 A5 4E 1F, info, length) is 12 bytes, a 16-bit header
// (F8 72 4E 1F, info, length) is 8 bytes, and either is taken only if the low
// five bits of the info byte equal wanted_data_type. After a header the next
// floor(bit_count/8) bytes are passed through as payload, the final one with
// last set; a burst of no payload bytes gives a single beat with last and
// empty_burst set and payload_byte zero. Payload bytes are never searched for
// preambles. in_stall is raised only while an output beat waits on out_stall.
// wanted_data_type should be written while the block is idle; it is always
// ready and resets to 1.
// ----------------------------------------------------------------------------
module pcm_burst_preamble_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  wanted_data_type,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic [1:0]  data_mode,
	output logic [4:0]  data_type,
	output logic [23:0] bit_count,
	output logic        last,
	output logic        empty_burst
);
	import pbpd_pkg::*;

	// Control and header state.
	logic [4:0]        want_q;
	win_t              win_q;
	logic [FILL_W-1:0] fill_q;
	logic              in_payload_q;
	logic [LEFT_W-1:0] left_q;
	logic [1:0]        mode_q;
	logic [4:0]        type_q;
	logic [23:0]       bits_q;

	// Output register.
	logic              out_valid_q;
	logic [7:0]        pay_q;
	logic [1:0]        omode_q;
	logic [4:0]        otype_q;
	logic [23:0]       obits_q;
	logic              last_q;
	logic              empty_q;

	logic              in_fire;
	logic              out_fire;
	logic              out_set;

	// Hunting datapath.
	win_t              win_app;
	logic [FILL_W-1:0] n_app;
	win_t              sh     [WIN_DEPTH];
	logic [1:0]        verd   [WIN_DEPTH];
	logic              found;
	logic [FILL_W-1:0] ksel;
	logic [1:0]        verd_sel;
	win_t              win_sel;
	logic [7:0]        info;
	logic [23:0]       hdr_bits;
	logic [LEFT_W-1:0] hdr_bytes;
	logic [LEFT_W-1:0] left_dec;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign in_fire   = in_valid & ~in_stall;
	assign out_fire  = out_valid_q & ~out_stall;

	// An accepted beat yields an output beat when it is a payload byte or when
	// it completes a header of no payload bytes.
	assign out_set = in_fire & (in_payload_q |
		((verd_sel == VERD_ACC24 || verd_sel == VERD_ACC16) && hdr_bytes == '0));

	// Append the new byte behind the current fill.
	always_comb begin
		win_app = win_q;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if (FILL_W'(i) == fill_q) win_app[i] = stream_byte;
		end
		n_app = fill_q + FILL_W'(1);
	end

	// Every start offset judged on its own.
	always_comb begin
		for (int k = 0; k < WIN_DEPTH; k++) begin
			sh[k] = '0;
			for (int i = 0; i < WIN_DEPTH; i++) begin
				if (i + k < WIN_DEPTH) sh[k][i] = win_app[i + k];
			end
			verd[k] = judge_front(sh[k], n_app - FILL_W'(k), want_q);
		end
	end

	// The first offset that is not dropped becomes the window front.
	always_comb begin
		found    = 1'b0;
		ksel     = '0;
		verd_sel = VERD_WAIT;
		win_sel  = '0;
		for (int k = 0; k < WIN_DEPTH; k++) begin
			if (!found && FILL_W'(k) < n_app && verd[k] != VERD_DROP) begin
				found    = 1'b1;
				ksel     = FILL_W'(k);
				verd_sel = verd[k];
				win_sel  = sh[k];
			end
		end
	end

	always_comb begin
		if (verd_sel == VERD_ACC24) begin
			info     = win_sel[8];
			hdr_bits = {win_sel[9], win_sel[10], win_sel[11]};
		end else begin
			info     = win_sel[5];
			hdr_bits = {8'h00, win_sel[6], win_sel[7]};
		end
		hdr_bytes = hdr_bits[23:3];
		left_dec  = left_q - LEFT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_q       <= 5'd1;
			fill_q       <= '0;
			in_payload_q <= 1'b0;
			left_q       <= '0;
			mode_q       <= '0;
			type_q       <= '0;
			bits_q       <= '0;
			win_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) want_q <= wanted_data_type;
			out_valid_q <= out_set | (out_valid_q & ~out_fire);
			if (in_fire) begin
				if (in_payload_q) begin
					left_q       <= left_dec;
					in_payload_q <= (left_dec != '0);
				end else if (verd_sel == VERD_ACC24 || verd_sel == VERD_ACC16) begin
					mode_q <= info[6:5];
					type_q <= info[4:0];
					bits_q <= hdr_bits;
					fill_q <= '0;
					left_q <= hdr_bytes;
					if (hdr_bytes != '0) begin
						in_payload_q <= 1'b1;
					end
				end else begin
					win_q  <= win_sel;
					fill_q <= found ? (n_app - ksel) : '0;
				end
			end
		end
	end

	// Output payload; the header fields for an empty burst come straight off
	// the header being accepted.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (in_payload_q) begin
				pay_q   <= stream_byte;
				omode_q <= mode_q;
				otype_q <= type_q;
				obits_q <= bits_q;
				last_q  <= (left_dec == '0);
				empty_q <= 1'b0;
			end else begin
				pay_q   <= 8'h00;
				omode_q <= info[6:5];
				otype_q <= info[4:0];
				obits_q <= hdr_bits;
				last_q  <= 1'b1;
				empty_q <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = pay_q;
	assign data_mode    = omode_q;
	assign data_type    = otype_q;
	assign bit_count    = obits_q;
	assign last         = last_q;
	assign empty_burst  = empty_q;

	// The window never holds a complete header between beats.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WIN_DEPTH - 1))
		else $error("header window fill out of range");

	// In payload there is always at least one byte still owed.
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> left_q != '0)
		else $error("payload phase with no bytes left");

	// An empty burst result leaves the block hunting.
	a_empty_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_q) |-> (!in_payload_q && last_q))
		else $error("empty burst result while still in payload");

	// A result taken in payload with last clear means more payload follows.
	a_more_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_payload_q && left_q != LEFT_W'(1)) |=> (in_payload_q && !last_q))
		else $error("payload ended early");

endmodule

// File: tb/pcm_burst_preamble_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_burst_preamble_deframer_test: self-checking bench for the burst deframer
// A short table of hand-written beats is followed by random phases under
// several data type settings. Each accepted stream byte goes through a
// behavioral deframer, and each output beat is checked field by field
// against the oldest predicted beat.
// ----------------------------------------------------------------------------
module pcm_burst_preamble_deframer_test;

	// Stall and gap bursts are short, so a long run of cycles with no handshake
	// at all means the block hung.
	localparam int HANG_LIMIT   = 2000;
	localparam int PHASE_BYTES  = 360;
	localparam int SETTLE_TICKS = 4;
	localparam int MAX_PRINTS   = 50;

	// Sync words in stream order, index 0 first on the wire.
	localparam logic [0:5][7:0] PRE24 = {8'h96, 8'hf8, 8'h72, 8'ha5, 8'h4e, 8'h1f};
	localparam logic [0:3][7:0] PRE16 = {8'hf8, 8'h72, 8'h4e, 8'h1f};

	typedef enum logic [1:0] {
		H_WAIT,
		H_DROP,
		H_TAKE24,
		H_TAKE16
	} hunt_e;

	typedef struct packed {
		logic [7:0]  payload;
		logic [1:0]  mode;
		logic [4:0]  dtype;
		logic [23:0] bits;
		logic        last;
		logic        empty;
	} beat_t;

	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		beat_t      want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  wanted_data_type = 5'd1;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  stream_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  payload_byte;
	logic [1:0]  data_mode;
	logic [4:0]  data_type;
	logic [23:0] bit_count;
	logic        last;
	logic        empty_burst;

	pcm_burst_preamble_deframer dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.wanted_data_type (wanted_data_type),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.stream_byte      (stream_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.payload_byte     (payload_byte),
		.data_mode        (data_mode),
		.data_type        (data_type),
		.bit_count        (bit_count),
		.last             (last),
		.empty_burst      (empty_burst)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Behavioral deframer state. It mirrors what the block holds: the
	// header window being hunted, the burst in progress and the wanted
	// data type register.
	// ------------------------------------------------------------------
	logic [7:0]  hunt_win [12];
	int          hunt_fill = 0;
	bit          in_burst = 1'b0;
	logic [20:0] burst_left = '0;
	logic [1:0]  held_mode = '0;
	logic [4:0]  held_type = '0;
	logic [23:0] held_bits = '0;
	logic [4:0]  want_type = 5'd1;

	beat_t pending_beats[$];
	row_t  directed_rows[$];
	beat_t no_beat = '0;

	bit calm = 1'b0;       // when set, neither side inserts gaps or stalls
	int mismatches = 0;
	int bytes_fed = 0;
	int beats_checked = 0;
	int bursts_done = 0;
	int empties_seen = 0;
	int settings_used = 1;
	int stall_left = 0;
	int hang_count = 0;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, what);
	endtask

	// Drops the byte at the front of the header window.
	function automatic void shift_window();
		int i;
		if (hunt_fill == 0) return;
		for (i = 0; i < 11; i++) hunt_win[i] = hunt_win[i + 1];
		hunt_win[11] = 8'h00;
		hunt_fill--;
	endfunction

	// Decides what to do with the window front. A front that can no longer
	// be the start of either preamble, or whose data type is known to be
	// unwanted, is dropped; a front that still could be waits for more bytes.
	function automatic hunt_e judge_window();
		int i;
		if (hunt_fill == 0) return H_WAIT;
		if (hunt_win[0] == PRE24[0]) begin
			for (i = 0; i < 6 && i < hunt_fill; i++)
				if (hunt_win[i] != PRE24[i]) return H_DROP;
			if (hunt_fill < 9) return H_WAIT;
			if (hunt_win[8][4:0] != want_type) return H_DROP;
			if (hunt_fill < 12) return H_WAIT;
			return H_TAKE24;
		end
		if (hunt_win[0] == PRE16[0]) begin
			for (i = 0; i < 4 && i < hunt_fill; i++)
				if (hunt_win[i] != PRE16[i]) return H_DROP;
			if (hunt_fill < 6) return H_WAIT;
			if (hunt_win[5][4:0] != want_type) return H_DROP;
			if (hunt_fill < 8) return H_WAIT;
			return H_TAKE16;
		end
		return H_DROP;
	endfunction

	// Advances the deframer by one stream byte. Returns 1 when the byte gives
	// an output beat, which is then placed in r.
	function automatic bit deframe_byte(input logic [7:0] b, output beat_t r);
		hunt_e      verdict;
		logic [7:0] info;
		int         i;
		r = '0;
		// Inside a burst, bytes pass straight through and are never hunted.
		if (in_burst) begin
			burst_left = burst_left - 21'd1;
			r.payload  = b;
			r.mode     = held_mode;
			r.dtype    = held_type;
			r.bits     = held_bits;
			r.last     = (burst_left == 21'd0);
			if (burst_left == 21'd0) in_burst = 1'b0;
			return 1'b1;
		end
		if (hunt_fill >= 12) shift_window();
		hunt_win[hunt_fill] = b;
		hunt_fill++;
		// Several dead bytes may fall off the front on one byte.
		verdict = judge_window();
		while (verdict == H_DROP) begin
			shift_window();
			verdict = judge_window();
		end
		if (verdict == H_WAIT) return 1'b0;
		if (verdict == H_TAKE24) begin
			info      = hunt_win[8];
			held_bits = {hunt_win[9], hunt_win[10], hunt_win[11]};
		end else begin
			info      = hunt_win[5];
			held_bits = {8'h00, hunt_win[6], hunt_win[7]};
		end
		// The error flag in bit 7 of the info byte plays no part.
		held_mode  = info[6:5];
		held_type  = info[4:0];
		burst_left = held_bits[23:3];
		for (i = 0; i < 12; i++) hunt_win[i] = 8'h00;
		hunt_fill = 0;
		if (burst_left != 21'd0) begin
			in_burst = 1'b1;
			return 1'b0;
		end
		// Fewer than eight bits: one beat flags the burst as empty.
		r.mode  = held_mode;
		r.dtype = held_type;
		r.bits  = held_bits;
		r.last  = 1'b1;
		r.empty = 1'b1;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Sender. A beat is held until the edge that takes it; a random gap may
	// come before it unless the run is calm.
	// ------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b, input bit typed, input beat_t typed_want);
		beat_t predicted;
		bit    produced;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_fed++;
		produced = deframe_byte(b, predicted);
		// A hand-typed row stands for itself; the deframer state still moves.
		if (typed) pending_beats.push_back(typed_want);
		else if (produced) pending_beats.push_back(predicted);
	endtask

	task automatic feed(input logic [7:0] b);
		push_byte(b, 1'b0, no_beat);
	endtask

	// Lets the block drain: all predicted beats out, then a further wait for its
	// registered output in case the last byte gave no beat.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_wanted(input logic [4:0] v);
		cfg_valid        <= 1'b1;
		wanted_data_type <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		want_type = v;
		settings_used++;
	endtask

	// Payload bytes lean toward sync values so that a burst body that looks
	// like a preamble is seen to pass through untouched.
	function automatic logic [7:0] payload_pick();
		if ($urandom_range(0, 3) == 0) return PRE24[$urandom_range(0, 5)];
		return 8'($urandom);
	endfunction

	// One random stretch of stream: mostly whole headers with a payload,
	// the rest broken preambles and loose noise.
	task automatic random_stretch(input logic [4:0] want);
		int          kind;
		int          i;
		int          n;
		logic [4:0]  t;
		logic [7:0]  info;
		logic [15:0] bits;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			t    = ($urandom_range(0, 99) < 85) ? want : 5'($urandom);
			info = {1'($urandom), 2'($urandom), t};
			n    = $urandom_range(0, 99);
			if (n < 10) bits = 16'($urandom_range(0, 7));
			else if (n < 96) bits = 16'($urandom_range(8, 200));
			else bits = 16'($urandom_range(201, 2047));
			if ($urandom_range(0, 1) == 1) begin
				for (i = 0; i < 6; i++) feed(PRE24[i]);
				feed(8'($urandom));
				feed(8'($urandom));
				feed(info);
				feed(8'h00);
				feed(bits[15:8]);
				feed(bits[7:0]);
			end else begin
				for (i = 0; i < 4; i++) feed(PRE16[i]);
				feed(8'($urandom));
				feed(info);
				feed(bits[15:8]);
				feed(bits[7:0]);
			end
			for (i = 0; i < bits / 8; i++) feed(payload_pick());
		end else if (kind < 82) begin
			// A preamble cut short by a stray byte.
			if ($urandom_range(0, 1) == 1) begin
				n = $urandom_range(1, 5);
				for (i = 0; i < n; i++) feed(PRE24[i]);
			end else begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++) feed(PRE16[i]);
			end
			feed(8'($urandom));
		end else begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++) feed(payload_pick());
		end
	endtask

	function automatic void plain_row(input logic [7:0] b);
		row_t r;
		r       = '0;
		r.b     = b;
		directed_rows.push_back(r);
	endfunction

	function automatic void checked_row(input logic [7:0] b, input logic [7:0] payload,
		input logic [1:0] mode, input logic [4:0] dtype, input logic [23:0] bits,
		input logic lst, input logic empty);
		row_t r;
		r              = '0;
		r.b            = b;
		r.typed        = 1'b1;
		r.want.payload = payload;
		r.want.mode    = mode;
		r.want.dtype   = dtype;
		r.want.bits    = bits;
		r.want.last    = lst;
		r.want.empty   = empty;
		directed_rows.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Receiver and checker. Each output beat taken is compared with the
	// oldest prediction; stall comes in random bursts.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		beat_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_beats.size() == 0) begin
					report_mismatch($sformatf("beat with payload %02h and no prediction",
						payload_byte));
				end else begin
					want = pending_beats.pop_front();
					if (payload_byte !== want.payload)
						report_mismatch($sformatf("payload_byte %02h, want %02h",
							payload_byte, want.payload));
					if (data_mode !== want.mode)
						report_mismatch($sformatf("data_mode %0d, want %0d",
							data_mode, want.mode));
					if (data_type !== want.dtype)
						report_mismatch($sformatf("data_type %0d, want %0d",
							data_type, want.dtype));
					if (bit_count !== want.bits)
						report_mismatch($sformatf("bit_count %0d, want %0d",
							bit_count, want.bits));
					if (last !== want.last)
						report_mismatch($sformatf("last %b, want %b", last, want.last));
					if (empty_burst !== want.empty)
						report_mismatch($sformatf("empty_burst %b, want %b",
							empty_burst, want.empty));
					beats_checked++;
					if (want.last) bursts_done++;
					if (want.empty) empties_seen++;
				end
			end
			if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 4);
			out_stall <= (stall_left != 0);
			if (stall_left != 0) stall_left--;
		end
	end

	// Hang watchdog: counts cycles in which no handshake completes.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready))
			hang_count = 0;
		else
			hang_count++;
		if (hang_count == HANG_LIMIT) begin
			$display("no handshake for %0d cycles, giving up", HANG_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int         i;
		int         phase;
		int         phase_start;
		logic [4:0] want;
		for (i = 0; i < 12; i++) hunt_win[i] = 8'h00;

		// Directed beats. The first header is a 16-bit one whose info byte
		// carries the error flag and mode 1, with a length of seven bits, so
		// it closes at once as an empty burst. Then a 24-bit preamble broken
		// after two bytes, and a real 24-bit header of three payload bytes
		// whose body starts with sync bytes that must not be hunted.
		plain_row(8'hf8);
		plain_row(8'h72);
		plain_row(8'h4e);
		plain_row(8'h1f);
		plain_row(8'hff);
		plain_row(8'ha1);
		plain_row(8'h00);
		checked_row(8'h07, 8'h00, 2'd1, 5'd1, 24'd7, 1'b1, 1'b1);
		plain_row(8'h96);
		plain_row(8'hf8);
		plain_row(8'h00);
		plain_row(8'h96);
		plain_row(8'hf8);
		plain_row(8'h72);
		plain_row(8'ha5);
		plain_row(8'h4e);
		plain_row(8'h1f);
		plain_row(8'h00);
		plain_row(8'h00);
		plain_row(8'h41);
		plain_row(8'h00);
		plain_row(8'h00);
		plain_row(8'h18);
		checked_row(8'hf8, 8'hf8, 2'd2, 5'd1, 24'd24, 1'b0, 1'b0);
		checked_row(8'h72, 8'h72, 2'd2, 5'd1, 24'd24, 1'b0, 1'b0);
		checked_row(8'hff, 8'hff, 2'd2, 5'd1, 24'd24, 1'b1, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			push_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].want);
		settle();

		// Random phases, each under its own data type: both extremes first,
		// then two random ones. The last phase runs without gaps or stalls.
		// Each phase closes with the sender holding off until every predicted
		// beat is out, so the register is only written while idle.
		for (phase = 0; phase < 4; phase++) begin
			if (phase == 0) want = 5'd0;
			else if (phase == 1) want = 5'd31;
			else want = 5'($urandom);
			calm = (phase == 3);
			write_wanted(want);
			phase_start = bytes_fed;
			while (bytes_fed - phase_start < PHASE_BYTES) random_stretch(want);
			// Finish any burst in progress before the register changes.
			while (in_burst) feed(payload_pick());
			settle();
		end
		repeat (2 * SETTLE_TICKS) @(posedge clk);

		$display("fed %0d stream bytes under %0d data type settings", bytes_fed,
			settings_used);
		$display("checked %0d output beats closing %0d bursts, %0d of them empty",
			beats_checked, bursts_done, empties_seen);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule
